// ===== hdl/vm_value_stack_top_defines.svh =====
// Assertion macros for the value stack checker
`ifndef VM_VALUE_STACK_TOP_DEFINES_SVH
`define VM_VALUE_STACK_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define VMVS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define VMVS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, active during reset
`define VMVS_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/vmvs_pkg.sv =====
// Shared types, codes and widths of the value stack
package vmvs_pkg;

    localparam int KIND_W   = 3;
    localparam int IDX_W    = 12;
    localparam int CNT_W    = 10;
    localparam int TAG_W    = 4;
    localparam int PAY_W    = 64;
    localparam int STATUS_W = 2;
    localparam int DEPTH_W  = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int UCNT_W   = 6;

    localparam int DEF_STACK_DEPTH    = 256;
    localparam int DEF_UPVALUE_SLOTS  = 32;
    localparam int DEF_REGISTRY_INDEX = -1024;

    localparam logic [KIND_W-1:0] KIND_PUSH    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POP     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_GET     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SET     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SET_TOP = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ROTATE  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_COPY    = 3'd6;
    localparam logic [KIND_W-1:0] KIND_UNUSED  = 3'd7;

    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_INVALID = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_NIL_TAG   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_TAG = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPV_COUNT = 2'd2;

    localparam logic [1:0] WH_STACK    = 2'd0;
    localparam logic [1:0] WH_REGISTRY = 2'd1;
    localparam logic [1:0] WH_UPVALUE  = 2'd2;
    localparam logic [1:0] WH_NONE     = 2'd3;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [PAY_W-1:0] payload;
    } t_slot;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        t_slot               value;
        logic                index_valid;
        logic [DEPTH_W-1:0]  depth;
    } t_result;

endpackage

// ===== hdl/vmvs_ram.sv =====
// Generic RAM with one write port and one registered read port
module vmvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/vm_value_stack_top.sv =====
// Value stack of tagged slots: top level with slot and upvalue memories
// Push, pop, get, set, push_copy and shrinking set_top finish in S_EXEC; a new item is
// accepted only in S_IDLE, once the last result has gone to the output register.
// Growing set_top writes the padded slots one by one in S_PAD (one slot RAM write port).
// Rotate runs three reversals, swapping each slot pair through S_RLO, S_RHI, S_WLO and S_WHI.
// Synchronous active-low reset clears control, top, registry and upvalue valid bits and resets
// the register settings; the slot memory is not cleared since slots above the top are never read.
module vm_value_stack_top import vmvs_pkg::*; #(
    parameter int STACK_DEPTH    = DEF_STACK_DEPTH,
    parameter int UPVALUE_SLOTS  = DEF_UPVALUE_SLOTS,
    parameter int REGISTRY_INDEX = DEF_REGISTRY_INDEX
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [KIND_W-1:0]          i_kind,
    input  logic signed [IDX_W-1:0]    i_index,
    input  logic signed [CNT_W-1:0]    i_count,
    input  logic [TAG_W-1:0]           i_tag,
    input  logic [PAY_W-1:0]           i_payload,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [STATUS_W-1:0]        o_status,
    output logic [TAG_W-1:0]           o_value_tag,
    output logic [PAY_W-1:0]           o_value_payload,
    output logic                       o_index_valid,
    output logic [DEPTH_W-1:0]         o_depth,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int TW  = $clog2(STACK_DEPTH + 1);
    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int UAW = (UPVALUE_SLOTS > 1) ? $clog2(UPVALUE_SLOTS) : 1;
    localparam int SW  = ((TW > IDX_W) ? TW : IDX_W) + 2;
    localparam int SLOT_W = $bits(t_slot);
    localparam logic signed [SW-1:0] REG_S  = SW'(REGISTRY_INDEX);
    localparam logic signed [SW-1:0] DEP_S  = SW'(STACK_DEPTH);
    localparam logic signed [SW-1:0] UPV_S  = SW'(UPVALUE_SLOTS);
    localparam logic signed [SW-1:0] ONE_S  = SW'(1);
    localparam logic [TW-1:0]        FULL_T = TW'(STACK_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_PAD  = 3'd2;
    localparam logic [2:0] S_RLO  = 3'd3;
    localparam logic [2:0] S_RHI  = 3'd4;
    localparam logic [2:0] S_WLO  = 3'd5;
    localparam logic [2:0] S_WHI  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]              r_state, n_state;
    logic [TW-1:0]           r_top, n_top;
    logic [TAG_W-1:0]        r_nil, r_table;
    logic [UCNT_W-1:0]       r_ucnt;
    logic [TAG_W-1:0]        r_reg_tag;
    logic [PAY_W-1:0]        r_reg_pay;
    logic [UPVALUE_SLOTS-1:0] r_uvld;

    logic [KIND_W-1:0]       r_kind;
    logic signed [SW-1:0]    r_abs;
    logic [1:0]              r_where;
    logic [UAW-1:0]          r_upos;
    logic signed [CNT_W-1:0] r_cnt;
    logic [TAG_W-1:0]        r_tag;
    logic [PAY_W-1:0]        r_pay;

    logic [TW-1:0]           r_nt, n_nt;
    logic signed [SW-1:0]    r_lo, n_lo, r_hi, n_hi, r_m, n_m;
    logic [1:0]              r_ph, n_ph;
    t_slot                   r_sa;

    logic                    r_ovalid;
    t_result                 r_out, r_res, res, out_data;
    logic                    fin, out_free, out_load, hold_res;

    logic signed [SW-1:0]    idx_s, top_s, abs_s, lim_s, u_s, t_s, cnt_s, mag_s, m_s;
    logic [1:0]              dec_where;
    logic [AW-1:0]           dec_raddr;

    logic                    st_we;
    logic [AW-1:0]           st_waddr, st_raddr;
    t_slot                   st_wdata, st_rd;
    logic                    uv_we;
    t_slot                   uv_rd, rv;
    logic                    reg_we;
    logic                    accept;

    assign accept = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign idx_s = SW'(i_index);
    assign top_s = signed'(SW'(r_top));
    assign abs_s = (idx_s <= REG_S || idx_s >= 0) ? idx_s : idx_s + top_s;
    assign lim_s = (signed'(SW'(r_ucnt)) > UPV_S) ? UPV_S : signed'(SW'(r_ucnt));
    assign u_s   = REG_S - abs_s - ONE_S;

    always_comb begin
        if (abs_s == REG_S) begin
            dec_where = WH_REGISTRY;
        end else if (abs_s < REG_S) begin
            dec_where = (u_s < lim_s) ? WH_UPVALUE : WH_NONE;
        end else if (abs_s >= 0 && abs_s < top_s) begin
            dec_where = WH_STACK;
        end else begin
            dec_where = WH_NONE;
        end
        dec_raddr = (i_kind == KIND_POP) ? AW'(r_top - TW'(1)) : abs_s[AW-1:0];
    end

    vmvs_ram #(.WIDTH(SLOT_W), .DEPTH(STACK_DEPTH)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rd)
    );

    vmvs_ram #(.WIDTH(SLOT_W), .DEPTH(UPVALUE_SLOTS)) u_upv_ram (
        .i_clk   (i_clk),
        .i_we    (uv_we),
        .i_waddr (r_upos),
        .i_wdata ({r_tag, r_pay}),
        .i_raddr (u_s[UAW-1:0]),
        .o_rdata (uv_rd)
    );

    assign t_s   = top_s - ONE_S;
    assign cnt_s = SW'(r_cnt);
    assign mag_s = (cnt_s < 0) ? -cnt_s : cnt_s;
    assign m_s   = (cnt_s >= 0) ? t_s - cnt_s : r_abs - cnt_s - ONE_S;
    assign out_free = !r_ovalid || i_ready;

    always_comb begin
        unique case (r_where)
            WH_REGISTRY: rv = {r_reg_tag, r_reg_pay};
            WH_UPVALUE:  rv = r_uvld[r_upos] ? uv_rd : '0;
            WH_STACK:    rv = st_rd;
            default:     rv = {r_nil, {PAY_W{1'b0}}};
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_top    = r_top;
        n_nt     = r_nt;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_m      = r_m;
        n_ph     = r_ph;
        fin      = 1'b0;
        res.status      = STAT_OK;
        res.value       = {r_nil, {PAY_W{1'b0}}};
        res.index_valid = 1'b0;
        res.depth       = '0;
        st_we    = 1'b0;
        st_waddr = r_top[AW-1:0];
        st_wdata = {r_tag, r_pay};
        st_raddr = dec_raddr;
        uv_we    = 1'b0;
        reg_we   = 1'b0;
        out_load = 1'b0;
        out_data = r_res;
        hold_res = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                fin = 1'b1;
                unique case (r_kind)
                    KIND_PUSH: begin
                        if (r_top == FULL_T) begin
                            res.status = STAT_OVERFLOW;
                        end else begin
                            st_we = 1'b1;
                            n_top = r_top + TW'(1);
                        end
                    end
                    KIND_POP: begin
                        if (r_top == '0) begin
                            res.status = STAT_UNDERFLOW;
                        end else begin
                            n_top = r_top - TW'(1);
                            res.value = st_rd;
                        end
                    end
                    KIND_GET, KIND_COPY: begin
                        res.value = rv;
                        res.index_valid = (r_where != WH_NONE);
                        if (r_kind == KIND_COPY) begin
                            if (r_top == FULL_T) begin
                                res.status = STAT_OVERFLOW;
                            end else begin
                                st_we = 1'b1;
                                st_wdata = rv;
                                n_top = r_top + TW'(1);
                            end
                        end
                    end
                    KIND_SET: begin
                        priority if (r_abs == REG_S) begin
                            if (r_tag == r_table) begin
                                reg_we = 1'b1;
                                res.index_valid = 1'b1;
                            end else begin
                                res.status = STAT_INVALID;
                            end
                        end else if (r_abs < REG_S) begin
                            if (r_where == WH_UPVALUE) begin
                                uv_we = 1'b1;
                                res.index_valid = 1'b1;
                            end
                        end else if (r_abs >= 0 && r_abs < top_s) begin
                            st_we = 1'b1;
                            st_waddr = r_abs[AW-1:0];
                            res.index_valid = 1'b1;
                        end else if (r_abs == top_s) begin
                            if (r_top == FULL_T) begin
                                res.status = STAT_OVERFLOW;
                            end else begin
                                st_we = 1'b1;
                                n_top = r_top + TW'(1);
                            end
                        end else begin
                            res.status = STAT_INVALID;
                        end
                    end
                    KIND_SET_TOP: begin
                        priority if (r_abs < 0) begin
                            res.status = STAT_UNDERFLOW;
                        end else if (r_abs > DEP_S) begin
                            res.status = STAT_OVERFLOW;
                        end else if (r_abs > top_s) begin
                            fin = 1'b0;
                            n_nt = r_abs[TW-1:0];
                            n_state = S_PAD;
                        end else begin
                            res.index_valid = 1'b1;
                            n_top = r_abs[TW-1:0];
                        end
                    end
                    KIND_ROTATE: begin
                        if (r_where != WH_STACK) begin
                            res.status = STAT_INVALID;
                        end else if (mag_s > top_s - r_abs) begin
                            res.status = STAT_INVALID;
                            res.index_valid = 1'b1;
                        end else begin
                            fin = 1'b0;
                            n_lo = r_abs;
                            n_hi = m_s;
                            n_m = m_s;
                            n_ph = 2'd0;
                            n_state = S_RLO;
                        end
                    end
                    default: begin
                        res.status = STAT_INVALID;
                    end
                endcase
            end
            S_PAD: begin
                st_we = 1'b1;
                st_wdata = {r_nil, {PAY_W{1'b0}}};
                n_top = r_top + TW'(1);
                if (n_top == r_nt) begin
                    fin = 1'b1;
                    res.index_valid = 1'b1;
                end
            end
            S_RLO: begin
                st_raddr = r_lo[AW-1:0];
                if (r_lo < r_hi) begin
                    n_state = S_RHI;
                end else begin
                    unique case (r_ph)
                        2'd0: begin
                            n_lo = r_m + ONE_S;
                            n_hi = t_s;
                            n_ph = 2'd1;
                        end
                        2'd1: begin
                            n_lo = r_abs;
                            n_hi = t_s;
                            n_ph = 2'd2;
                        end
                        default: begin
                            fin = 1'b1;
                            res.index_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_RHI: begin
                st_raddr = r_hi[AW-1:0];
                n_state = S_WLO;
            end
            S_WLO: begin
                st_we = 1'b1;
                st_waddr = r_lo[AW-1:0];
                st_wdata = st_rd;
                n_state = S_WHI;
            end
            S_WHI: begin
                st_we = 1'b1;
                st_waddr = r_hi[AW-1:0];
                st_wdata = r_sa;
                n_lo = r_lo + ONE_S;
                n_hi = r_hi - ONE_S;
                n_state = S_RLO;
            end
            default: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
        endcase
        res.depth = DEPTH_W'(n_top);
        if (fin) begin
            if (out_free) begin
                out_load = 1'b1;
                out_data = res;
                n_state = S_IDLE;
            end else begin
                hold_res = 1'b1;
                n_state = S_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_top     <= '0;
            r_nil     <= '0;
            r_table   <= TAG_W'(5);
            r_ucnt    <= '0;
            r_reg_tag <= '0;
            r_reg_pay <= '0;
            r_uvld    <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_top   <= n_top;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_NIL_TAG:   r_nil   <= i_cfg_data[TAG_W-1:0];
                    CFG_TABLE_TAG: r_table <= i_cfg_data[TAG_W-1:0];
                    CFG_UPV_COUNT: r_ucnt  <= i_cfg_data[UCNT_W-1:0];
                    default: ;
                endcase
            end
            if (reg_we) begin
                r_reg_tag <= r_tag;
                r_reg_pay <= r_pay;
            end
            if (uv_we) begin
                r_uvld[r_upos] <= 1'b1;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= i_kind;
            r_abs   <= abs_s;
            r_where <= dec_where;
            r_upos  <= u_s[UAW-1:0];
            r_cnt   <= i_count;
            r_tag   <= i_tag;
            r_pay   <= i_payload;
        end
        r_nt <= n_nt;
        r_lo <= n_lo;
        r_hi <= n_hi;
        r_m  <= n_m;
        r_ph <= n_ph;
        if (r_state == S_RHI) begin
            r_sa <= st_rd;
        end
        if (hold_res) begin
            r_res <= res;
        end
        if (out_load) begin
            r_out <= out_data;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_status        = r_out.status;
    assign o_value_tag     = r_out.value.tag;
    assign o_value_payload = r_out.value.payload;
    assign o_index_valid   = r_out.index_valid;
    assign o_depth         = r_out.depth;

endmodule

// ===== hdl/vmvs_chk.sv =====
// Port-level checker for the value stack, bound to the top level
`include "vm_value_stack_top_defines.svh"
module vmvs_chk import vmvs_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_ready,
    input logic                o_valid,
    input logic                i_ready,
    input logic [STATUS_W-1:0] o_status,
    input logic                o_index_valid
);

    logic uflow;

    assign uflow = o_valid && (o_status == STAT_UNDERFLOW);

    `VMVS_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !o_valid, "result valid after reset")
    `VMVS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid, "item dropped")
    `VMVS_ASSERT_NOW(a_underflow, i_clk, i_rst_n, uflow, !o_index_valid, "underflow with valid index")
    `VMVS_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "ready right after accept")

endmodule

bind vm_value_stack_top vmvs_chk u_vmvs_chk (.*);

// ===== tb/vm_value_stack_checker.sv =====
// Value stack checker: watches the item, result and register channels and compares results
module vm_value_stack_checker import vmvs_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic [KIND_W-1:0]       i_kind,
    input  logic signed [IDX_W-1:0] i_index,
    input  logic signed [CNT_W-1:0] i_count,
    input  logic [TAG_W-1:0]        i_tag,
    input  logic [PAY_W-1:0]        i_payload,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic [STATUS_W-1:0]     i_status,
    input  logic [TAG_W-1:0]        i_value_tag,
    input  logic [PAY_W-1:0]        i_value_payload,
    input  logic                    i_index_valid,
    input  logic [DEPTH_W-1:0]      i_depth,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    output int                      o_errors,
    output int                      o_pending,
    output int                      o_results,
    output int                      o_stack_top
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = DEF_STACK_DEPTH;
    localparam int UPVS  = DEF_UPVALUE_SLOTS;
    localparam int REGI  = DEF_REGISTRY_INDEX;

    logic [TAG_W-1:0]  slot_tag [SLOTS];
    logic [PAY_W-1:0]  slot_pay [SLOTS];
    logic [TAG_W-1:0]  upv_tag [UPVS];
    logic [PAY_W-1:0]  upv_pay [UPVS];
    logic [TAG_W-1:0]  reg_tag;
    logic [PAY_W-1:0]  reg_pay;
    int                stack_top;
    logic [TAG_W-1:0]  nil_tag;
    logic [TAG_W-1:0]  table_tag;
    logic [UCNT_W-1:0] upv_count;
    t_result           expected_q [$];
    int                errors;
    int                results;

    assign o_errors    = errors;
    assign o_pending   = expected_q.size();
    assign o_results   = results;
    assign o_stack_top = stack_top;

    function automatic int absolute(int idx);
        if (idx <= REGI || idx >= 0) return idx;
        return idx + stack_top;
    endfunction

    function automatic logic [1:0] locate(int idx, output int pos);
        int a;
        int lim;
        a = absolute(idx);
        lim = (upv_count < UPVS) ? int'(upv_count) : UPVS;
        pos = 0;
        if (a == REGI) return WH_REGISTRY;
        if (a < REGI) begin
            if (REGI - a - 1 < lim) begin
                pos = REGI - a - 1;
                return WH_UPVALUE;
            end
            return WH_NONE;
        end
        if (a >= 0 && a < stack_top) begin
            pos = a;
            return WH_STACK;
        end
        return WH_NONE;
    endfunction

    function automatic void reverse(int lo, int hi);
        logic [TAG_W-1:0] t;
        logic [PAY_W-1:0] p;
        while (lo < hi) begin
            t = slot_tag[lo];
            p = slot_pay[lo];
            slot_tag[lo] = slot_tag[hi];
            slot_pay[lo] = slot_pay[hi];
            slot_tag[hi] = t;
            slot_pay[hi] = p;
            lo++;
            hi--;
        end
    endfunction

    function automatic void push_slot(logic [TAG_W-1:0] t, logic [PAY_W-1:0] p,
                                      inout logic [STATUS_W-1:0] st);
        if (stack_top >= SLOTS) begin
            st = STAT_OVERFLOW;
        end else begin
            slot_tag[stack_top] = t;
            slot_pay[stack_top] = p;
            stack_top++;
        end
    endfunction

    function automatic t_result apply_item(logic [KIND_W-1:0] kind, int idx, int cnt,
                                           logic [TAG_W-1:0] tag, logic [PAY_W-1:0] pay);
        t_result r;
        logic [1:0] wh;
        int pos, a, t, len, mag, m;
        r.status = STAT_OK;
        r.value.tag = nil_tag;
        r.value.payload = '0;
        r.index_valid = 1'b0;
        case (kind)
            KIND_PUSH: push_slot(tag, pay, r.status);
            KIND_POP: begin
                if (stack_top < 1) begin
                    r.status = STAT_UNDERFLOW;
                end else begin
                    stack_top--;
                    r.value.tag = slot_tag[stack_top];
                    r.value.payload = slot_pay[stack_top];
                    slot_tag[stack_top] = nil_tag;
                    slot_pay[stack_top] = '0;
                end
            end
            KIND_GET, KIND_COPY: begin
                wh = locate(idx, pos);
                if (wh == WH_REGISTRY) begin
                    r.value.tag = reg_tag;
                    r.value.payload = reg_pay;
                end else if (wh == WH_UPVALUE) begin
                    r.value.tag = upv_tag[pos];
                    r.value.payload = upv_pay[pos];
                end else if (wh == WH_STACK) begin
                    r.value.tag = slot_tag[pos];
                    r.value.payload = slot_pay[pos];
                end
                r.index_valid = (wh != WH_NONE);
                if (kind == KIND_COPY) push_slot(r.value.tag, r.value.payload, r.status);
            end
            KIND_SET: begin
                a = absolute(idx);
                if (a == REGI) begin
                    if (tag == table_tag) begin
                        reg_tag = tag;
                        reg_pay = pay;
                        r.index_valid = 1'b1;
                    end else begin
                        r.status = STAT_INVALID;
                    end
                end else if (a < REGI) begin
                    if (locate(idx, pos) == WH_UPVALUE) begin
                        upv_tag[pos] = tag;
                        upv_pay[pos] = pay;
                        r.index_valid = 1'b1;
                    end
                end else if (a >= 0 && a < stack_top) begin
                    slot_tag[a] = tag;
                    slot_pay[a] = pay;
                    r.index_valid = 1'b1;
                end else if (a == stack_top) begin
                    push_slot(tag, pay, r.status);
                end else begin
                    r.status = STAT_INVALID;
                end
            end
            KIND_SET_TOP: begin
                a = absolute(idx);
                if (a < 0) begin
                    r.status = STAT_UNDERFLOW;
                end else if (a > SLOTS) begin
                    r.status = STAT_OVERFLOW;
                end else begin
                    r.index_valid = 1'b1;
                    while (stack_top < a) begin
                        slot_tag[stack_top] = nil_tag;
                        slot_pay[stack_top] = '0;
                        stack_top++;
                    end
                    while (stack_top > a) begin
                        stack_top--;
                        slot_tag[stack_top] = nil_tag;
                        slot_pay[stack_top] = '0;
                    end
                end
            end
            KIND_ROTATE: begin
                if (locate(idx, pos) != WH_STACK) begin
                    r.status = STAT_INVALID;
                end else begin
                    t = stack_top - 1;
                    len = t - pos + 1;
                    mag = (cnt < 0) ? -cnt : cnt;
                    r.index_valid = 1'b1;
                    if (mag > len) begin
                        r.status = STAT_INVALID;
                    end else begin
                        m = (cnt >= 0) ? t - cnt : pos - cnt - 1;
                        reverse(pos, m);
                        reverse(m + 1, t);
                        reverse(pos, t);
                    end
                end
            end
            default: r.status = STAT_INVALID;
        endcase
        r.depth = stack_top[DEPTH_W-1:0];
        return r;
    endfunction

    task automatic check_field(string name, logic [PAY_W-1:0] exp, logic [PAY_W-1:0] act);
        if (exp !== act) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
        end
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_tag[i] = '0;
                slot_pay[i] = '0;
            end
            for (int i = 0; i < UPVS; i++) begin
                upv_tag[i] = '0;
                upv_pay[i] = '0;
            end
            reg_tag = '0;
            reg_pay = '0;
            stack_top = 0;
            nil_tag = '0;
            table_tag = 4'd5;
            upv_count = '0;
            expected_q.delete();
            errors = 0;
            results = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_NIL_TAG:   nil_tag = i_cfg_data[TAG_W-1:0];
                    CFG_TABLE_TAG: table_tag = i_cfg_data[TAG_W-1:0];
                    CFG_UPV_COUNT: upv_count = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                expected_q.push_back(apply_item(i_kind, int'(i_index), int'(i_count),
                                                i_tag, i_payload));
            if (i_out_valid && i_out_ready) begin
                results++;
                if (expected_q.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing expected, expected none, actual %0h",
                             $time, {i_status, i_value_tag, i_value_payload});
                end else begin
                    e = expected_q.pop_front();
                    check_field("status", e.status, i_status);
                    check_field("value_tag", e.value.tag, i_value_tag);
                    check_field("value_payload", e.value.payload, i_value_payload);
                    check_field("index_valid", e.index_valid, i_index_valid);
                    check_field("depth", e.depth, i_depth);
                end
            end
        end
    end
endmodule

// ===== tb/vm_value_stack_top_test.sv =====
// Value stack testbench top: drives items and register writes, gives the verdict
module vm_value_stack_top_test import vmvs_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REGI = DEF_REGISTRY_INDEX;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic [KIND_W-1:0]       i_kind;
    logic signed [IDX_W-1:0] i_index;
    logic signed [CNT_W-1:0] i_count;
    logic [TAG_W-1:0]        i_tag;
    logic [PAY_W-1:0]        i_payload;
    logic                    o_valid;
    logic                    i_ready;
    logic [STATUS_W-1:0]     o_status;
    logic [TAG_W-1:0]        o_value_tag;
    logic [PAY_W-1:0]        o_value_payload;
    logic                    o_index_valid;
    logic [DEPTH_W-1:0]      o_depth;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    int errors, pending, results, stack_top;
    int items_sent, cfg_writes, settings;
    bit calm_tx, calm_rx;
    logic [TAG_W-1:0] cur_table_tag;

    vm_value_stack_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_kind(i_kind), .i_index(i_index), .i_count(i_count),
        .i_tag(i_tag), .i_payload(i_payload),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_status(o_status), .o_value_tag(o_value_tag),
        .o_value_payload(o_value_payload), .o_index_valid(o_index_valid),
        .o_depth(o_depth),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    vm_value_stack_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_ready(o_ready),
        .i_kind(i_kind), .i_index(i_index), .i_count(i_count),
        .i_tag(i_tag), .i_payload(i_payload),
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_status(o_status), .i_value_tag(o_value_tag),
        .i_value_payload(o_value_payload), .i_index_valid(o_index_valid),
        .i_depth(o_depth),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending), .o_results(results),
        .o_stack_top(stack_top)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic send(logic [KIND_W-1:0] kind, int idx, int cnt,
                        logic [TAG_W-1:0] tag, logic [PAY_W-1:0] pay);
        int gap;
        gap = calm_tx ? 0 : $urandom_range(0, 12);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_kind = kind;
        i_index = IDX_W'(idx);
        i_count = CNT_W'(cnt);
        i_tag = tag;
        i_payload = pay;
        i_valid = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_index = idx;
        i_cfg_data = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        cfg_writes++;
    endtask

    task automatic apply_setting(logic [CFG_DATA_W-1:0] nil, logic [CFG_DATA_W-1:0] tbl,
                                 logic [CFG_DATA_W-1:0] ucnt);
        drain();
        cfg_write(CFG_NIL_TAG, nil);
        cfg_write(CFG_TABLE_TAG, tbl);
        cfg_write(CFG_UPV_COUNT, ucnt);
        cur_table_tag = tbl[TAG_W-1:0];
        settings++;
    endtask

    function automatic int pick_index();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return $urandom_range(0, stack_top);
        if (r < 75) return -int'($urandom_range(1, stack_top + 1));
        if (r < 83) return REGI;
        if (r < 93) return REGI - 1 - int'($urandom_range(0, 34));
        return int'($signed(12'($urandom)));
    endfunction

    task automatic random_item();
        int r, cnt;
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0] tag;
        r = $urandom_range(0, 99);
        if (stack_top > 48) r = (r < 50) ? 25 : r;
        if (r < 22) kind = KIND_PUSH;
        else if (r < 37) kind = KIND_POP;
        else if (r < 52) kind = KIND_GET;
        else if (r < 67) kind = KIND_SET;
        else if (r < 75) kind = KIND_SET_TOP;
        else if (r < 87) kind = KIND_ROTATE;
        else if (r < 97) kind = KIND_COPY;
        else kind = KIND_UNUSED;
        if ($urandom_range(0, 99) < 70) cnt = int'($urandom_range(0, 2 * stack_top)) - stack_top;
        else cnt = int'($urandom_range(0, 512)) - 256;
        if (cnt > 256) cnt = 256;
        if (cnt < -256) cnt = -256;
        tag = ($urandom_range(0, 1) != 0) ? cur_table_tag : 4'($urandom);
        send(kind, pick_index(), cnt, tag, {$urandom, $urandom});
    endtask

    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            n = (calm_rx || !i_rst_n) ? 0 : $urandom_range(0, 12);
            if (n > 0) begin
                i_ready = 1'b0;
                repeat (n) @(negedge i_clk);
            end
            i_ready = 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin
        int guard;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_kind = '0;
        i_index = '0;
        i_count = '0;
        i_tag = '0;
        i_payload = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        calm_tx = 1'b0;
        calm_rx = 1'b0;
        cur_table_tag = 4'd5;
        items_sent = 0;
        cfg_writes = 0;
        settings = 1;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        send(KIND_POP, 0, 0, 0, 0);
        send(KIND_GET, 3, 0, 0, 0);
        send(KIND_SET, -1025, 0, 4'hF, '1);
        send(KIND_SET, REGI, 0, 4'd3, 64'h1234);
        send(KIND_SET, REGI, 0, 4'd5, 64'hDEAD_BEEF_0000_0001);
        send(KIND_GET, REGI, 0, 0, 0);
        send(KIND_PUSH, 0, 0, 4'hF, '1);
        send(KIND_PUSH, 0, 0, 4'h0, '0);
        send(KIND_SET, 2, 0, 4'hA, 64'h5555_AAAA_5555_AAAA);
        send(KIND_SET, 7, 0, 4'h1, 64'h1);
        send(KIND_SET_TOP, -9, 0, 0, 0);
        send(KIND_SET_TOP, REGI, 0, 0, 0);
        send(KIND_SET_TOP, 257, 0, 0, 0);
        send(KIND_SET_TOP, 8, 0, 0, 0);
        send(KIND_ROTATE, 0, 3, 0, 0);
        send(KIND_ROTATE, 1, -2, 0, 0);
        send(KIND_ROTATE, 2, 0, 0, 0);
        send(KIND_ROTATE, 4, 9, 0, 0);
        send(KIND_ROTATE, REGI, 1, 0, 0);
        send(KIND_COPY, -8, 0, 0, 0);
        send(KIND_COPY, 2000, 0, 0, 0);
        send(KIND_UNUSED, 0, 0, 0, 0);
        send(KIND_SET_TOP, 256, 0, 0, 0);
        send(KIND_PUSH, 0, 0, 4'h2, 64'h2);
        send(KIND_COPY, 0, 0, 0, 0);
        send(KIND_SET, 256, 0, 4'h2, 64'h2);
        send(KIND_SET_TOP, 0, 0, 0, 0);

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: apply_setting(6'd0, 6'd5, 6'd4);
                1: apply_setting(6'h3F, 6'h0F, 6'd32);
                2: apply_setting(6'd0, 6'd0, 6'd0);
                3: apply_setting(6'h2A, 6'h15, 6'h3F);
                default: apply_setting(6'($urandom), 6'($urandom), 6'($urandom_range(0, 40)));
            endcase
            calm_tx = (phase == 2);
            calm_rx = (phase == 2) || (phase == 4);
            for (int i = 0; i < 240; i++) random_item();
        end

        @(negedge i_clk);
        i_valid = 1'b0;
        guard = 0;
        while (pending != 0 && guard < 200_000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (50) @(negedge i_clk);
        $display("Covered %0d items under %0d register settings (%0d writes).",
                 items_sent, settings, cfg_writes);
        $display("Checked %0d results, %0d still outstanding, %0d mismatches.",
                 results, pending, errors);
        if (errors == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
